// ===== hdl/ixh_pkg.sv =====
// ----------------------------------------------------------------------------
// ixh_pkg
// Shared widths, codes, controller/datapath interface types and helpers for
// the indexed d-ary min-heap.
// ----------------------------------------------------------------------------
`default_nettype none

package ixh_pkg;

  localparam int MAX_ITEMS = 256;
  localparam int KEY_BITS  = 32;
  localparam int MAX_ARITY = 8;

  localparam int ITEM_W  = 9;
  localparam int SLOT_W  = 9;
  localparam int ADDR_W  = $clog2(MAX_ITEMS);
  localparam int ARITY_W = 4;
  localparam int CH_W    = SLOT_W + ARITY_W + 1;
  localparam int RCP_SH  = SLOT_W + 3;
  localparam int RCP_W   = RCP_SH + 1;

  // ceil(2^RCP_SH / d), exact floor division for every heap slot
  localparam logic [RCP_W-1:0] RECIP [16] = '{
    RCP_W'(0), RCP_W'(0),
    RCP_W'((2**RCP_SH + 1) / 2), RCP_W'((2**RCP_SH + 2) / 3),
    RCP_W'((2**RCP_SH + 3) / 4), RCP_W'((2**RCP_SH + 4) / 5),
    RCP_W'((2**RCP_SH + 5) / 6), RCP_W'((2**RCP_SH + 6) / 7),
    RCP_W'((2**RCP_SH + 7) / 8), RCP_W'(0), RCP_W'(0), RCP_W'(0),
    RCP_W'(0), RCP_W'(0), RCP_W'(0), RCP_W'(0)
  };

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_DELMIN = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [4:0] OP_NOP     = 5'd0;
  localparam logic [4:0] OP_LOAD    = 5'd1;
  localparam logic [4:0] OP_CLEAR   = 5'd2;
  localparam logic [4:0] OP_BAD     = 5'd3;
  localparam logic [4:0] OP_EMPTY   = 5'd4;
  localparam logic [4:0] OP_RDROOT  = 5'd5;
  localparam logic [4:0] OP_TGTIN   = 5'd6;
  localparam logic [4:0] OP_TGTROOT = 5'd7;
  localparam logic [4:0] OP_ABSENT  = 5'd8;
  localparam logic [4:0] OP_TAKE    = 5'd9;
  localparam logic [4:0] OP_LAST    = 5'd10;
  localparam logic [4:0] OP_LKEY    = 5'd11;
  localparam logic [4:0] OP_INS     = 5'd12;
  localparam logic [4:0] OP_PAR     = 5'd13;
  localparam logic [4:0] OP_RDP     = 5'd14;
  localparam logic [4:0] OP_RDPK    = 5'd15;
  localparam logic [4:0] OP_UPMV    = 5'd16;
  localparam logic [4:0] OP_CHILD   = 5'd17;
  localparam logic [4:0] OP_RDC     = 5'd18;
  localparam logic [4:0] OP_RDCK    = 5'd19;
  localparam logic [4:0] OP_CMPC    = 5'd20;
  localparam logic [4:0] OP_DNMV    = 5'd21;
  localparam logic [4:0] OP_PLACE   = 5'd22;
  localparam logic [4:0] OP_OUT     = 5'd23;

  typedef struct packed {
    logic [4:0] op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       item_ok;
    logic       cnt_zero;
    logic       absent;
    logic       last_eq;
    logic       up;
    logic       root;
    logic       par_gt;
    logic       no_child;
    logic       more;
    logic       less;
    logic       out_busy;
  } sts_t;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] t;
    t = s - SLOT_W'(1);
    return t[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ixh_dp.sv =====
// ----------------------------------------------------------------------------
// ixh_dp
// Datapath: heap slot, item slot and key memories, arity register, sift
// working registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ixh_dp
  import ixh_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire cmd_t                       cmd,
  output sts_t                            sts,
  input  wire logic                       cfg_we,
  input  wire logic [ARITY_W-1:0]         cfg_wdata,
  input  wire logic [1:0]                 in_action,
  input  wire logic [ITEM_W-1:0]          in_item,
  input  wire logic signed [KEY_BITS-1:0] in_key,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [ITEM_W-1:0]               out_result_item,
  output logic [1:0]                      out_status,
  output logic [SLOT_W-1:0]               out_occupancy
);

  logic [SLOT_W-1:0]          si_mem [MAX_ITEMS];
  logic [SLOT_W-1:0]          is_mem [MAX_ITEMS];
  logic signed [KEY_BITS-1:0] ik_mem [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]       is_vld_r;

  logic [ITEM_W-1:0]          si_rd_r;
  logic [SLOT_W-1:0]          is_rd_r;
  logic                       vld_rd_r;
  logic signed [KEY_BITS-1:0] ik_rd_r;

  logic [ARITY_W-1:0]         arity_r;
  logic [SLOT_W-1:0]          cnt_r;
  logic                       out_valid_r;
  logic [ITEM_W-1:0]          ores_r;
  logic [1:0]                 ost_r;
  logic [SLOT_W-1:0]          oocc_r;

  logic [1:0]                 act_r;
  logic [ITEM_W-1:0]          item_r;
  logic signed [KEY_BITS-1:0] key_r;
  logic [ITEM_W-1:0]          res_r;
  logic [1:0]                 st_r;
  logic [ITEM_W-1:0]          tgt_r;
  logic signed [KEY_BITS-1:0] tkey_r;
  logic [ITEM_W-1:0]          mv_it_r;
  logic signed [KEY_BITS-1:0] mv_key_r;
  logic [SLOT_W-1:0]          x_r;
  logic [SLOT_W-1:0]          px_r;
  logic [ITEM_W-1:0]          p_it_r;
  logic [SLOT_W-1:0]          fst_r;
  logic [SLOT_W-1:0]          y_r;
  logic [SLOT_W-1:0]          lim_r;
  logic [ITEM_W-1:0]          c_it_r;
  logic [SLOT_W-1:0]          best_r;
  logic [ITEM_W-1:0]          best_it_r;
  logic signed [KEY_BITS-1:0] best_key_r;

  logic [ARITY_W-1:0]         d_eff;
  logic [SLOT_W-1:0]          is_rd;
  logic [SLOT_W-1:0]          pn;
  logic [SLOT_W+RCP_W-1:0]    prod;
  logic [SLOT_W-1:0]          px_w;
  logic [CH_W-1:0]            fst_w;
  logic [CH_W-1:0]            last_w;
  logic [SLOT_W-1:0]          lim_w;

  logic [ADDR_W-1:0]          si_ra, ik_ra, is_ra;
  logic                       si_we, is_we, ik_we, is_clr1, is_clrall;
  logic [ADDR_W-1:0]          si_wa, is_wa, ik_wa;
  logic [ITEM_W-1:0]          si_wd;
  logic [SLOT_W-1:0]          is_wd;

  always_comb begin
    if (arity_r < ARITY_W'(2)) begin
      d_eff = ARITY_W'(2);
    end else if (arity_r > ARITY_W'(MAX_ARITY)) begin
      d_eff = ARITY_W'(MAX_ARITY);
    end else begin
      d_eff = arity_r;
    end
  end

  assign is_rd  = vld_rd_r ? is_rd_r : '0;
  assign pn     = x_r - SLOT_W'(2);
  assign prod   = (SLOT_W+RCP_W)'(pn) * (SLOT_W+RCP_W)'(RECIP[d_eff]);
  assign px_w   = prod[RCP_SH +: SLOT_W] + SLOT_W'(1);
  assign fst_w  = CH_W'(d_eff) * (CH_W'(x_r) - CH_W'(1)) + CH_W'(2);
  assign last_w = fst_w + CH_W'(d_eff) - CH_W'(1);
  assign lim_w  = (last_w > CH_W'(cnt_r)) ? cnt_r : last_w[SLOT_W-1:0];

  always_comb begin
    sts.act      = act_r;
    sts.item_ok  = (item_r != '0) && (item_r <= ITEM_W'(MAX_ITEMS));
    sts.cnt_zero = (cnt_r == '0);
    sts.absent   = (is_rd == '0);
    sts.last_eq  = (si_rd_r == tgt_r);
    sts.up       = (ik_rd_r <= tkey_r);
    sts.root     = (x_r == SLOT_W'(1));
    sts.par_gt   = (ik_rd_r > mv_key_r);
    sts.no_child = (fst_w > CH_W'(cnt_r));
    sts.more     = (y_r < lim_r);
    sts.less     = (best_key_r < mv_key_r);
    sts.out_busy = out_valid_r && out_stall;
  end

  always_comb begin
    si_ra     = '0;
    ik_ra     = '0;
    is_ra     = '0;
    si_we     = 1'b0;
    is_we     = 1'b0;
    ik_we     = 1'b0;
    is_clr1   = 1'b0;
    is_clrall = 1'b0;
    si_wa     = slot_addr(x_r);
    si_wd     = mv_it_r;
    is_wa     = slot_addr(mv_it_r);
    is_wd     = x_r;
    ik_wa     = slot_addr(item_r);
    case (cmd.op)
      OP_CLEAR:   is_clrall = 1'b1;
      OP_RDROOT:  si_ra = '0;
      OP_TGTIN:   is_ra = slot_addr(item_r);
      OP_TGTROOT: is_ra = slot_addr(si_rd_r);
      OP_TAKE: begin
        si_ra = slot_addr(cnt_r);
        ik_ra = slot_addr(tgt_r);
      end
      OP_LAST: begin
        ik_ra   = slot_addr(si_rd_r);
        is_clr1 = 1'b1;
        is_wa   = slot_addr(tgt_r);
      end
      OP_INS:     ik_we = 1'b1;
      OP_RDP:     si_ra = slot_addr(px_r);
      OP_RDPK:    ik_ra = slot_addr(si_rd_r);
      OP_UPMV: begin
        si_we = 1'b1;
        si_wd = p_it_r;
        is_we = 1'b1;
        is_wa = slot_addr(p_it_r);
      end
      OP_RDC:     si_ra = slot_addr(y_r);
      OP_RDCK:    ik_ra = slot_addr(si_rd_r);
      OP_DNMV: begin
        si_we = 1'b1;
        si_wd = best_it_r;
        is_we = 1'b1;
        is_wa = slot_addr(best_it_r);
      end
      OP_PLACE: begin
        si_we = 1'b1;
        is_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (si_we) begin
      si_mem[si_wa] <= si_wd;
    end
    si_rd_r <= si_mem[si_ra];
    if (ik_we) begin
      ik_mem[ik_wa] <= key_r;
    end
    ik_rd_r <= ik_mem[ik_ra];
    if (is_we) begin
      is_mem[is_wa] <= is_wd;
    end
    is_rd_r  <= is_mem[is_ra];
    vld_rd_r <= is_vld_r[is_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_vld_r    <= '0;
      arity_r     <= ARITY_W'(2);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (is_clrall) begin
        is_vld_r <= '0;
      end else if (is_we) begin
        is_vld_r[is_wa] <= 1'b1;
      end else if (is_clr1) begin
        is_vld_r[is_wa] <= 1'b0;
      end
      if (cfg_we) begin
        arity_r <= cfg_wdata;
      end
      case (cmd.op)
        OP_CLEAR: cnt_r <= '0;
        OP_LAST:  cnt_r <= cnt_r - SLOT_W'(1);
        OP_INS:   cnt_r <= cnt_r + SLOT_W'(1);
        default:  ;
      endcase
      if (cmd.op == OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        act_r  <= in_action;
        item_r <= in_item;
        key_r  <= in_key;
        res_r  <= '0;
        st_r   <= ST_OK;
      end
      OP_BAD:   st_r <= ST_RANGE;
      OP_EMPTY: st_r <= ST_NONE;
      OP_ABSENT: begin
        st_r  <= ST_NONE;
        res_r <= '0;
      end
      OP_TGTIN: begin
        tgt_r <= item_r;
        res_r <= (act_r == ACT_REMOVE) ? item_r : '0;
      end
      OP_TGTROOT: begin
        tgt_r <= si_rd_r;
        res_r <= si_rd_r;
      end
      OP_TAKE: x_r <= is_rd;
      OP_LAST: begin
        mv_it_r <= si_rd_r;
        tkey_r  <= ik_rd_r;
      end
      OP_LKEY: mv_key_r <= ik_rd_r;
      OP_INS: begin
        mv_it_r  <= item_r;
        mv_key_r <= key_r;
        x_r      <= cnt_r + SLOT_W'(1);
      end
      OP_PAR:  px_r <= px_w;
      OP_RDPK: p_it_r <= si_rd_r;
      OP_UPMV: x_r <= px_r;
      OP_CHILD: begin
        fst_r <= fst_w[SLOT_W-1:0];
        y_r   <= fst_w[SLOT_W-1:0];
        lim_r <= lim_w;
      end
      OP_RDCK: c_it_r <= si_rd_r;
      OP_CMPC: begin
        if ((y_r == fst_r) || (ik_rd_r < best_key_r)) begin
          best_r     <= y_r;
          best_it_r  <= c_it_r;
          best_key_r <= ik_rd_r;
        end
        y_r <= y_r + SLOT_W'(1);
      end
      OP_DNMV: x_r <= best_r;
      OP_OUT: begin
        ores_r <= res_r;
        ost_r  <= st_r;
        oocc_r <= cnt_r;
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_result_item = ores_r;
  assign out_status      = ost_r;
  assign out_occupancy   = oocc_r;

endmodule

`default_nettype wire

// ===== hdl/ixh_ctrl.sv =====
// ----------------------------------------------------------------------------
// ixh_ctrl
// Sequencer: decodes each action and steps the datapath through take-out,
// sift-up and sift-down one memory access at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module ixh_ctrl
  import ixh_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_ROOT  = 5'd2;
  localparam logic [4:0] S_SLOT  = 5'd3;
  localparam logic [4:0] S_LAST  = 5'd4;
  localparam logic [4:0] S_LKEY  = 5'd5;
  localparam logic [4:0] S_INS   = 5'd6;
  localparam logic [4:0] S_UTEST = 5'd7;
  localparam logic [4:0] S_URDP  = 5'd8;
  localparam logic [4:0] S_URDK  = 5'd9;
  localparam logic [4:0] S_UCMP  = 5'd10;
  localparam logic [4:0] S_DSTRT = 5'd11;
  localparam logic [4:0] S_DRDS  = 5'd12;
  localparam logic [4:0] S_DRDK  = 5'd13;
  localparam logic [4:0] S_DCMP  = 5'd14;
  localparam logic [4:0] S_DDEC  = 5'd15;
  localparam logic [4:0] S_PLACE = 5'd16;
  localparam logic [4:0] S_END   = 5'd17;
  localparam logic [4:0] S_FIN   = 5'd18;

  logic [4:0] state_r, state_nxt;
  logic       ph_r, ph_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    cmd.op    = OP_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        ph_nxt = 1'b0;
        if (sts.act == ACT_CLEAR) begin
          cmd.op    = OP_CLEAR;
          state_nxt = S_FIN;
        end else if (sts.act == ACT_DELMIN) begin
          if (sts.cnt_zero) begin
            cmd.op    = OP_EMPTY;
            state_nxt = S_FIN;
          end else begin
            cmd.op    = OP_RDROOT;
            state_nxt = S_ROOT;
          end
        end else if (!sts.item_ok) begin
          cmd.op    = OP_BAD;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_TGTIN;
          state_nxt = S_SLOT;
        end
      end
      S_ROOT: begin
        cmd.op    = OP_TGTROOT;
        state_nxt = S_SLOT;
      end
      S_SLOT: begin
        if (!sts.absent) begin
          cmd.op    = OP_TAKE;
          state_nxt = S_LAST;
        end else if (sts.act == ACT_INSERT) begin
          state_nxt = S_INS;
        end else begin
          cmd.op    = OP_ABSENT;
          state_nxt = S_FIN;
        end
      end
      S_LAST: begin
        cmd.op    = OP_LAST;
        state_nxt = sts.last_eq ? S_END : S_LKEY;
      end
      S_LKEY: begin
        cmd.op    = OP_LKEY;
        state_nxt = sts.up ? S_UTEST : S_DSTRT;
      end
      S_INS: begin
        cmd.op    = OP_INS;
        ph_nxt    = 1'b1;
        state_nxt = S_UTEST;
      end
      S_UTEST: begin
        if (sts.root) begin
          state_nxt = S_PLACE;
        end else begin
          cmd.op    = OP_PAR;
          state_nxt = S_URDP;
        end
      end
      S_URDP: begin
        cmd.op    = OP_RDP;
        state_nxt = S_URDK;
      end
      S_URDK: begin
        cmd.op    = OP_RDPK;
        state_nxt = S_UCMP;
      end
      S_UCMP: begin
        if (sts.par_gt) begin
          cmd.op    = OP_UPMV;
          state_nxt = S_UTEST;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_DSTRT: begin
        cmd.op    = OP_CHILD;
        state_nxt = sts.no_child ? S_PLACE : S_DRDS;
      end
      S_DRDS: begin
        cmd.op    = OP_RDC;
        state_nxt = S_DRDK;
      end
      S_DRDK: begin
        cmd.op    = OP_RDCK;
        state_nxt = S_DCMP;
      end
      S_DCMP: begin
        cmd.op    = OP_CMPC;
        state_nxt = sts.more ? S_DRDS : S_DDEC;
      end
      S_DDEC: begin
        if (sts.less) begin
          cmd.op    = OP_DNMV;
          state_nxt = S_DSTRT;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.op    = OP_PLACE;
        state_nxt = S_END;
      end
      S_END: begin
        state_nxt = (!ph_r && (sts.act == ACT_INSERT)) ? S_INS : S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/indexed_dary_min_heap_top.sv =====
// ----------------------------------------------------------------------------
// indexed_dary_min_heap_top
// Indexed d-ary min-heap priority queue: insert/re-key, remove, delete-min
// and clear over items 1..MAX_ITEMS with signed keys.
// ----------------------------------------------------------------------------
//   channel | ports                                   | beat
//   in      | in_valid/in_stall, action, item, key    | one action
//   out     | out_valid/out_stall, result_item,       | one result per action
//           | status, occupancy                       |
//   cfg     | cfg_we, cfg_wdata                       | arity write
//
// Sift-up and sift-down levels are paced by the single read port of each heap
// memory; a re-key runs a take-out and then an insert.
// Reset: synchronous active low; clears item presence, count and arity (2).
// One action is in flight at a time; in_stall holds while it runs. A result
// waiting under out_stall does not block the next beat on the input side.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_dary_min_heap_top
  import ixh_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 in_action,
  input  wire logic [ITEM_W-1:0]          in_item,
  input  wire logic signed [KEY_BITS-1:0] in_key,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [ITEM_W-1:0]               out_result_item,
  output logic [1:0]                      out_status,
  output logic [SLOT_W-1:0]               out_occupancy,
  input  wire logic                       cfg_we,
  input  wire logic [ARITY_W-1:0]         cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  ixh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  ixh_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_action       (in_action),
    .in_item         (in_item),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_item (out_result_item),
    .out_status      (out_status),
    .out_occupancy   (out_occupancy)
  );

endmodule

`default_nettype wire
